### rtl/logg_pkg.sv
// Shared constants, codes and types of the log-odds occupancy grid.
// No dependencies; used by every other file of the block.
package logg_pkg;

    // grid geometry
    localparam int GRID_DIM   = 256;
    localparam int GRID_CELLS = GRID_DIM * GRID_DIM;
    localparam int ADDR_W     = $clog2(GRID_CELLS);

    // field widths
    localparam int POS_W  = 32;
    localparam int LO_W   = 16;
    localparam int IDX_W  = 17;
    localparam int HALF_W = 31;
    localparam int CPU_W  = 32;
    localparam int GSZ_W  = 9;
    localparam int THR_W  = 15;
    localparam int CNT_W  = 17;
    localparam int CLS_W  = 2;

    // mapping arithmetic
    localparam int FRAC_W     = 16;
    localparam int DIFF_W     = 34;
    localparam int MAG_W      = 34;
    localparam int PROD_W     = MAG_W + FRAC_W;
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);
    localparam int IDX_NEG_LIMIT = 1 << (IDX_W - 1);
    localparam int IDX_POS_LIMIT = (1 << (IDX_W - 1)) - 1;

    // occupied count saturation
    localparam logic [CNT_W-1:0] OCC_MAX = CNT_W'(65536);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_EXT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PU  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OCC_THR   = 3'd5;

    // request and class codes
    localparam logic REQ_WRITE = 1'b1;
    localparam logic [CLS_W-1:0] CLASS_FREE     = 2'd0;
    localparam logic [CLS_W-1:0] CLASS_UNKNOWN  = 2'd1;
    localparam logic [CLS_W-1:0] CLASS_OCCUPIED = 2'd2;

    // front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
        logic [HALF_W-1:0]       half_extent;
        logic [CPU_W-1:0]        cells_per_unit;
        logic [GSZ_W-1:0]        grid_size;
    } t_map_cfg;

    typedef struct packed {
        logic                    wr;
        logic signed [LO_W-1:0]  lin;
        logic                    inb;
        logic signed [IDX_W-1:0] row;
        logic signed [IDX_W-1:0] col;
        logic [ADDR_W-1:0]       addr;
    } t_job;

endpackage

### rtl/logg_if.sv
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on logg_pkg.
interface logg_req_if import logg_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic signed [LO_W-1:0]  log_odds_in;

    modport source(output valid, req_type, x_pos, y_pos, log_odds_in, input ready);
    modport sink(input valid, req_type, x_pos, y_pos, log_odds_in, output ready);
endinterface

interface logg_rsp_if import logg_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    in_bounds;
    logic signed [IDX_W-1:0] cell_row;
    logic signed [IDX_W-1:0] cell_col;
    logic signed [LO_W-1:0]  log_odds_out;
    logic [CLS_W-1:0]        cell_class;
    logic                    became_occupied;
    logic                    became_unoccupied;
    logic [CNT_W-1:0]        occupied_count;

    modport source(output valid, in_bounds, cell_row, cell_col, log_odds_out, cell_class,
                   became_occupied, became_unoccupied, occupied_count, input ready);
    modport sink(input valid, in_bounds, cell_row, cell_col, log_odds_out, cell_class,
                 became_occupied, became_unoccupied, occupied_count, output ready);
endinterface

interface logg_cfg_if import logg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

### rtl/logg_front.sv
// Front end: accepts requests, maps world position to row/column and checks bounds.
// Sequenced over sum, abs, multiply, round and bound steps. Depends on logg_pkg, logg_if.
module logg_front import logg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_enable,
    input  t_map_cfg   i_map_cfg,
    logg_req_if.sink   i_req,
    output t_job       o_job,
    output logic       o_job_valid,
    input  logic       i_job_ready
);

    localparam int Q_W = PROD_W + 1 - FRAC_W;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_SUM  = 3'd1;
    localparam logic [2:0] F_ABS  = 3'd2;
    localparam logic [2:0] F_MUL  = 3'd3;
    localparam logic [2:0] F_RND  = 3'd4;
    localparam logic [2:0] F_BND  = 3'd5;

    logic [2:0]               r_state, n_state;
    logic                     r_wr;
    logic signed [LO_W-1:0]   r_lin;
    logic signed [POS_W-1:0]  r_x, r_y;
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic [MAG_W-1:0]         r_magx, r_magy;
    logic                     r_negx, r_negy;
    logic [PROD_W-1:0]        r_ax, r_bx, r_ay, r_by;
    logic signed [IDX_W-1:0]  r_row, r_col;

    logic                     accept;
    logic [IDX_W-1:0]         eff_size;
    logic                     inb;
    logic [ADDR_W-1:0]        addr;

    function automatic logic signed [IDX_W-1:0] round_axis(
        input logic [PROD_W-1:0] a,
        input logic [PROD_W-1:0] b,
        input logic              neg
    );
        logic [PROD_W:0]         s;
        logic [Q_W-1:0]          q;
        logic signed [IDX_W-1:0] res;
        s = {1'b0, a} + (PROD_W+1)'(b >> FRAC_W) + (PROD_W+1)'(ROUND_HALF);
        q = s[PROD_W:FRAC_W];
        if (neg) begin
            if (q > Q_W'(IDX_NEG_LIMIT)) begin
                res = IDX_W'(IDX_NEG_LIMIT);
            end else begin
                res = IDX_W'(IDX_W'(0) - q[IDX_W-1:0]);
            end
        end else begin
            if (q > Q_W'(IDX_POS_LIMIT)) begin
                res = IDX_W'(IDX_POS_LIMIT);
            end else begin
                res = q[IDX_W-1:0];
            end
        end
        return res;
    endfunction

    assign i_req.ready = (r_state == F_IDLE) && i_enable;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (accept) n_state = F_SUM;
            F_SUM:  n_state = F_ABS;
            F_ABS:  n_state = F_MUL;
            F_MUL:  n_state = F_RND;
            F_RND:  n_state = F_BND;
            F_BND:  if (i_job_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_wr  <= i_req.req_type;
            r_lin <= i_req.log_odds_in;
            r_x   <= i_req.x_pos;
            r_y   <= i_req.y_pos;
        end
        if (r_state == F_SUM) begin
            r_dx <= DIFF_W'(r_x) - DIFF_W'(i_map_cfg.origin_x)
                    + $signed({3'b000, i_map_cfg.half_extent});
            r_dy <= DIFF_W'(r_y) - DIFF_W'(i_map_cfg.origin_y)
                    + $signed({3'b000, i_map_cfg.half_extent});
        end
        if (r_state == F_ABS) begin
            r_negx <= r_dx[DIFF_W-1];
            r_negy <= r_dy[DIFF_W-1];
            r_magx <= r_dx[DIFF_W-1] ? MAG_W'(-r_dx) : MAG_W'(r_dx);
            r_magy <= r_dy[DIFF_W-1] ? MAG_W'(-r_dy) : MAG_W'(r_dy);
        end
        if (r_state == F_MUL) begin
            r_ax <= PROD_W'(r_magx) * PROD_W'(i_map_cfg.cells_per_unit[CPU_W-1:FRAC_W]);
            r_bx <= PROD_W'(r_magx) * PROD_W'(i_map_cfg.cells_per_unit[FRAC_W-1:0]);
            r_ay <= PROD_W'(r_magy) * PROD_W'(i_map_cfg.cells_per_unit[CPU_W-1:FRAC_W]);
            r_by <= PROD_W'(r_magy) * PROD_W'(i_map_cfg.cells_per_unit[FRAC_W-1:0]);
        end
        if (r_state == F_RND) begin
            r_col <= round_axis(r_ax, r_bx, r_negx);
            r_row <= round_axis(r_ay, r_by, r_negy);
        end
    end

    always_comb begin
        eff_size = (IDX_W'(i_map_cfg.grid_size) < IDX_W'(GRID_DIM))
                 ? IDX_W'(i_map_cfg.grid_size) : IDX_W'(GRID_DIM);
        inb = !r_row[IDX_W-1] && !r_col[IDX_W-1]
           && ($unsigned(r_row) < eff_size) && ($unsigned(r_col) < eff_size);
        addr = inb ? ADDR_W'(ADDR_W'(r_row[IDX_W-2:0]) * ADDR_W'(GRID_DIM))
                     + ADDR_W'(r_col[IDX_W-2:0])
                   : '0;
    end

    assign o_job_valid = (r_state == F_BND);
    assign o_job.wr    = r_wr;
    assign o_job.lin   = r_lin;
    assign o_job.inb   = inb;
    assign o_job.row   = r_row;
    assign o_job.col   = r_col;
    assign o_job.addr  = addr;

endmodule

### rtl/logg_queue.sv
// Small FIFO of mapped, bounds-checked jobs between the front end and the grid back end.
// Depends on logg_pkg.
module logg_queue import logg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_job  i_push_job,
    output logic  o_full,
    input  logic  i_pop,
    output t_job  o_pop_job,
    output logic  o_empty
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_full    = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && !o_empty;
    assign o_pop_job = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/logg_back.sv
// Back end: grid memory with clearing pass, cell read-modify-write, occupied count,
// classification and the result register. Depends on logg_pkg, logg_if.
module logg_back import logg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [THR_W-1:0] i_thr,
    input  t_job             i_job,
    input  logic             i_job_valid,
    output logic             o_job_pop,
    output logic             o_clear_done,
    logg_rsp_if.source       o_rsp
);

    localparam logic [1:0] B_CLEAR = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_EXEC  = 2'd2;

    logic [LO_W-1:0]         r_grid [GRID_CELLS];
    logic [1:0]              r_state, n_state;
    logic [ADDR_W-1:0]       r_clr_addr;
    logic [LO_W-1:0]         r_rdata;
    t_job                    r_cur;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_out_valid;
    logic                    r_o_inb;
    logic signed [IDX_W-1:0] r_o_row, r_o_col;
    logic signed [LO_W-1:0]  r_o_val;
    logic [CLS_W-1:0]        r_o_cls;
    logic                    r_o_up, r_o_down;

    logic                    exec;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [LO_W-1:0]         mem_wdata;
    logic signed [IDX_W-1:0] thr, neg_thr, old17, lin17, val17;
    logic signed [LO_W-1:0]  val;
    logic                    up, down;
    logic [CLS_W-1:0]        cls;

    assign o_clear_done = (r_state != B_CLEAR);
    assign o_job_pop    = (r_state == B_IDLE) && i_job_valid && (!r_out_valid || o_rsp.ready);
    assign exec         = (r_state == B_EXEC);

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLEAR: if (r_clr_addr == ADDR_W'(GRID_CELLS - 1)) n_state = B_IDLE;
            B_IDLE:  if (o_job_pop) n_state = B_EXEC;
            B_EXEC:  n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        thr     = $signed({2'b00, i_thr});
        neg_thr = -thr;
        old17   = r_cur.inb ? IDX_W'($signed(r_rdata)) : '0;
        lin17   = IDX_W'(r_cur.lin);
        up      = r_cur.inb && (r_cur.wr == REQ_WRITE) && (old17 <= thr) && (lin17 > thr);
        down    = r_cur.inb && (r_cur.wr == REQ_WRITE) && (old17 > thr) && (lin17 <= thr);
        if (!r_cur.inb) begin
            val = '0;
        end else if (r_cur.wr == REQ_WRITE) begin
            val = r_cur.lin;
        end else begin
            val = $signed(r_rdata);
        end
        val17 = IDX_W'(val);
        if (val17 > thr) begin
            cls = CLASS_OCCUPIED;
        end else if (val17 < neg_thr) begin
            cls = CLASS_FREE;
        end else begin
            cls = CLASS_UNKNOWN;
        end
        n_count = r_count;
        if (up && (r_count < OCC_MAX)) begin
            n_count = r_count + 1'b1;
        end else if (down && (r_count != '0)) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        mem_we    = (r_state == B_CLEAR) || (exec && r_cur.inb && (r_cur.wr == REQ_WRITE));
        mem_waddr = (r_state == B_CLEAR) ? r_clr_addr : r_cur.addr;
        mem_wdata = (r_state == B_CLEAR) ? '0 : r_cur.lin;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_grid[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_rdata <= r_grid[i_job.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_cur <= i_job;
        end
        if (exec) begin
            r_o_inb  <= r_cur.inb;
            r_o_row  <= r_cur.row;
            r_o_col  <= r_cur.col;
            r_o_val  <= val;
            r_o_cls  <= cls;
            r_o_up   <= up;
            r_o_down <= down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.in_bounds         = r_o_inb;
    assign o_rsp.cell_row          = r_o_row;
    assign o_rsp.cell_col          = r_o_col;
    assign o_rsp.log_odds_out      = r_o_val;
    assign o_rsp.cell_class        = r_o_cls;
    assign o_rsp.became_occupied   = r_o_up;
    assign o_rsp.became_unoccupied = r_o_down;
    assign o_rsp.occupied_count    = r_count;

endmodule

### rtl/log_odds_occupancy_grid.sv
// Log-odds occupancy grid top level: config registers, front end, job queue, back end.
// The front end's mapping sequencer takes no new request until its current job has been
// handed to the queue, so it holds one request at a time.
// Reset is synchronous; afterwards a clearing pass zeroes all GRID_DIM*GRID_DIM (65536)
// cells of the grid memory, one cell a cycle, with request ready low; config is taken.
// Depends on logg_pkg, logg_if, logg_front, logg_queue, logg_back.
module log_odds_occupancy_grid import logg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    logg_cfg_if.sink    i_cfg,
    logg_req_if.sink    i_req,
    logg_rsp_if.source  o_rsp
);

    localparam logic [HALF_W-1:0] HALF_EXT_RST  = HALF_W'(8388608);
    localparam logic [CPU_W-1:0]  CELLS_PU_RST  = CPU_W'(65536);
    localparam logic [GSZ_W-1:0]  GRID_SIZE_RST = GSZ_W'(256);

    t_map_cfg         r_map_cfg;
    logic [THR_W-1:0] r_thr;
    logic             cfg_wr;

    t_job             front_job, queue_job;
    logic             front_valid, queue_full, queue_empty, back_pop, clear_done;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_cfg.origin_x       <= '0;
            r_map_cfg.origin_y       <= '0;
            r_map_cfg.half_extent    <= HALF_EXT_RST;
            r_map_cfg.cells_per_unit <= CELLS_PU_RST;
            r_map_cfg.grid_size      <= GRID_SIZE_RST;
            r_thr                    <= '0;
        end else if (cfg_wr) begin
            case (i_cfg.index)
                CFG_ORIGIN_X:  r_map_cfg.origin_x       <= i_cfg.data;
                CFG_ORIGIN_Y:  r_map_cfg.origin_y       <= i_cfg.data;
                CFG_HALF_EXT:  r_map_cfg.half_extent    <= i_cfg.data[HALF_W-1:0];
                CFG_CELLS_PU:  r_map_cfg.cells_per_unit <= i_cfg.data[CPU_W-1:0];
                CFG_GRID_SIZE: r_map_cfg.grid_size      <= i_cfg.data[GSZ_W-1:0];
                CFG_OCC_THR:   r_thr                    <= i_cfg.data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    logg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (clear_done),
        .i_map_cfg   (r_map_cfg),
        .i_req       (i_req),
        .o_job       (front_job),
        .o_job_valid (front_valid),
        .i_job_ready (!queue_full)
    );

    logg_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (front_valid),
        .i_push_job (front_job),
        .o_full     (queue_full),
        .i_pop      (back_pop),
        .o_pop_job  (queue_job),
        .o_empty    (queue_empty)
    );

    logg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_thr        (r_thr),
        .i_job        (queue_job),
        .i_job_valid  (!queue_empty),
        .o_job_pop    (back_pop),
        .o_clear_done (clear_done),
        .o_rsp        (o_rsp)
    );

    a_no_req_during_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !clear_done |-> !i_req.ready)
        else $error("request ready while grid clear is running");

    a_no_rsp_during_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !clear_done |-> !o_rsp.valid)
        else $error("result valid while grid clear is running");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.became_occupied && o_rsp.became_unoccupied))
        else $error("both threshold crossing flags set");

    a_oob_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.in_bounds |->
            o_rsp.log_odds_out == '0 && !o_rsp.became_occupied && !o_rsp.became_unoccupied)
        else $error("out-of-bounds result carries cell data");

endmodule
